/* rtl/gpx_pkg.sv */
`default_nettype none
package gpx_pkg;

   // glyph geometry and magnification limits
   localparam int GLYPH_WIDTH  = 8;
   localparam int GLYPH_HEIGHT = 16;
   localparam int MAX_SCALE    = 8;

   // field widths
   localparam int ADDR_W   = 40;
   localparam int COLOR_W  = 32;
   localparam int COORD_W  = 16;
   localparam int DIM_W    = 14;
   localparam int SCALE_W  = 4;
   localparam int FMT_W    = 2;
   localparam int ROW_W    = 4;
   localparam int SUBROW_W = 3;
   localparam int COL_W    = $clog2(GLYPH_WIDTH);
   localparam int DX_W     = $clog2(MAX_SCALE);
   localparam int PX_W     = $clog2(GLYPH_WIDTH * MAX_SCALE);

   // configuration register port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 40;

   localparam logic [CSR_INDEX_W-1:0] CSR_BASE_ADDRESS   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_LINE_STRIDE    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_PIXEL_FORMAT   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_DISPLAY_ENABLE = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCALE_FACTOR   = 3'd6;

   // pixel formats
   localparam logic [FMT_W-1:0] FMT_ARGB32 = 2'd0;
   localparam logic [FMT_W-1:0] FMT_RGB24  = 2'd1;
   localparam logic [FMT_W-1:0] FMT_RGB565 = 2'd2;
   localparam logic [FMT_W-1:0] FMT_NONE   = 2'd3;

   localparam logic [COLOR_W-1:0] TRANSPARENT_KEY = 32'hff00_0000;

   // configuration as seen by the datapath
   typedef struct packed {
      logic [ADDR_W-1:0]  base_address;
      logic [DIM_W-1:0]   frame_width;
      logic [DIM_W-1:0]   frame_height;
      logic [DIM_W-1:0]   line_stride;
      logic [FMT_W-1:0]   pixel_format;
      logic               display_enable;
      logic [SCALE_W-1:0] scale_factor;
   } gpx_cfg_type;

   // one pixel from the sequencer into the address pipeline
   typedef struct packed {
      logic                      valid;
      logic                      last;
      logic [PX_W-1:0]           px;
      logic [COLOR_W-1:0]        color;
      logic signed [COORD_W-1:0] origin_x;
      logic signed [COORD_W-1:0] origin_y;
      logic [ROW_W-1:0]          glyph_row;
      logic [SUBROW_W-1:0]       sub_row;
   } gpx_token_type;

   // zero counts as one, anything above the limit saturates
   function automatic logic [SCALE_W-1:0] eff_scale(input logic [SCALE_W-1:0] raw);
      logic [SCALE_W-1:0] s;
      s = raw;
      if (raw == '0) begin
         s = SCALE_W'(1);
      end else if (raw > SCALE_W'(MAX_SCALE)) begin
         s = SCALE_W'(MAX_SCALE);
      end
      return s;
   endfunction

endpackage
`default_nettype wire

/* rtl/glyph_row_pixel_expander.sv */
// Glyph row pixel expander: turns one 8-pixel glyph bitmap row into frame buffer
// pixel writes, one write per cycle, each glyph pixel repeated scale times across.
// Request: a transaction is taken at a clock edge with start high and busy low;
// req_* carries the bitmap, cell origin, glyph row, sub-row and both colours.
// Response: each pixel is on rsp_* for one cycle with rsp_strobe high; there is
// no back-pressure, the receiver must take every result. rsp_last_pixel marks
// the final pixel of a row; disabled writes still appear, with zeroed fields.
// CSR: register writes go over csr_valid/csr_ready (always ready) with csr_index
// and csr_data; change them only while no row is in flight.
// Throughput: one pixel per cycle from the column/replica counter, 8 * scale
// pixels per row; busy drops in the cycle of the last pixel so the next row
// follows with no gap.
// Pipeline: the first pixel of a row leaves the sequencer register, then
// passes five register stages for position, clipping and line product,
// linear index, byte offset and base add before it is on the ports.
// Reset: synchronous, clears the sequencer and pipeline valid bits and returns
// the registers to their defaults (format unsupported, scale one, rest zero).
`default_nettype none
module glyph_row_pixel_expander
   import gpx_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   output logic                           busy,
   input  wire logic [GLYPH_WIDTH-1:0]    req_glyph_bits,
   input  wire logic signed [COORD_W-1:0] req_origin_x,
   input  wire logic signed [COORD_W-1:0] req_origin_y,
   input  wire logic [ROW_W-1:0]          req_glyph_row,
   input  wire logic [SUBROW_W-1:0]       req_sub_row,
   input  wire logic [COLOR_W-1:0]        req_fg_color,
   input  wire logic [COLOR_W-1:0]        req_bg_color,
   output logic                           rsp_strobe,
   output logic                           rsp_write_enable,
   output logic [ADDR_W-1:0]              rsp_write_address,
   output logic [COLOR_W-1:0]             rsp_write_data,
   output logic [FMT_W-1:0]               rsp_write_size,
   output logic                           rsp_last_pixel,
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [CSR_DATA_W-1:0]     csr_data
);

   gpx_cfg_type   cfg;
   gpx_token_type token;

   // configuration registers
   gpx_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // column and replica sequencer
   gpx_sequencer u_sequencer (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .glyph_bits   (req_glyph_bits),
      .origin_x     (req_origin_x),
      .origin_y     (req_origin_y),
      .glyph_row    (req_glyph_row),
      .sub_row      (req_sub_row),
      .fg_color     (req_fg_color),
      .bg_color     (req_bg_color),
      .scale_factor (cfg.scale_factor),
      .token        (token)
   );

   // address and data pipeline
   gpx_pixel_pipe u_pixel_pipe (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .token             (token),
      .rsp_strobe        (rsp_strobe),
      .rsp_write_enable  (rsp_write_enable),
      .rsp_write_address (rsp_write_address),
      .rsp_write_data    (rsp_write_data),
      .rsp_write_size    (rsp_write_size),
      .rsp_last_pixel    (rsp_last_pixel)
   );

`ifndef NO_ASSERTIONS
   // an accepted row shows its first pixel after the fixed pipeline latency
   a_first_pixel: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##6 rsp_strobe)
      else $error("accepted row produced no pixel at the expected latency");

   // pixels of one row come as an unbroken run up to the last one
   a_row_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_last_pixel) |=> rsp_strobe)
      else $error("gap inside the pixel run of a row");

   // no write is enabled while the display, the pixel format or a zero base address rules it out
   a_write_gate: assert property (@(posedge clock) disable iff (reset)
      rsp_write_enable |-> (cfg.display_enable && cfg.pixel_format != FMT_NONE
                            && cfg.base_address != '0))
      else $error("write enabled with output disabled");

   // the sequencer hands out the last pixel exactly when it frees up
   a_busy_release: assert property (@(posedge clock) disable iff (reset)
      (token.valid && token.last) |-> !busy)
      else $error("busy held during the last pixel of a row");
`endif

endmodule
`default_nettype wire

/* rtl/gpx_csr.sv */
`default_nettype none
module gpx_csr
   import gpx_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data,
   output gpx_cfg_type                 cfg
);

   gpx_cfg_type cfg_ff;
   gpx_cfg_type cfg_in;

   // registers always take a write
   assign csr_ready = 1'b1;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_BASE_ADDRESS:   cfg_in.base_address   = csr_data[ADDR_W-1:0];
            CSR_FRAME_WIDTH:    cfg_in.frame_width    = csr_data[DIM_W-1:0];
            CSR_FRAME_HEIGHT:   cfg_in.frame_height   = csr_data[DIM_W-1:0];
            CSR_LINE_STRIDE:    cfg_in.line_stride    = csr_data[DIM_W-1:0];
            CSR_PIXEL_FORMAT:   cfg_in.pixel_format   = csr_data[FMT_W-1:0];
            CSR_DISPLAY_ENABLE: cfg_in.display_enable = csr_data[0];
            CSR_SCALE_FACTOR:   cfg_in.scale_factor   = csr_data[SCALE_W-1:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.base_address   <= '0;
         cfg_ff.frame_width    <= '0;
         cfg_ff.frame_height   <= '0;
         cfg_ff.line_stride    <= '0;
         cfg_ff.pixel_format   <= FMT_NONE;
         cfg_ff.display_enable <= 1'b0;
         cfg_ff.scale_factor   <= SCALE_W'(1);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

/* rtl/gpx_sequencer.sv */
`default_nettype none
module gpx_sequencer
   import gpx_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   output logic                           busy,
   input  wire logic [GLYPH_WIDTH-1:0]    glyph_bits,
   input  wire logic signed [COORD_W-1:0] origin_x,
   input  wire logic signed [COORD_W-1:0] origin_y,
   input  wire logic [ROW_W-1:0]          glyph_row,
   input  wire logic [SUBROW_W-1:0]       sub_row,
   input  wire logic [COLOR_W-1:0]        fg_color,
   input  wire logic [COLOR_W-1:0]        bg_color,
   input  wire logic [SCALE_W-1:0]        scale_factor,
   output gpx_token_type                  token
);

   logic                      active_ff, active_in;
   logic [COL_W-1:0]          col_ff, col_in;
   logic [DX_W-1:0]           dx_ff, dx_in;
   logic [PX_W-1:0]           px_ff, px_in;
   logic [GLYPH_WIDTH-1:0]    bits_ff;
   logic signed [COORD_W-1:0] origin_x_ff;
   logic signed [COORD_W-1:0] origin_y_ff;
   logic [ROW_W-1:0]          glyph_row_ff;
   logic [SUBROW_W-1:0]       sub_row_ff;
   logic [COLOR_W-1:0]        fg_ff;
   logic [COLOR_W-1:0]        bg_ff;

   logic [SCALE_W-1:0] scale;
   logic               dx_last;
   logic               last;
   logic               accept;

   assign scale   = eff_scale(scale_factor);
   assign dx_last = dx_ff == DX_W'(scale - SCALE_W'(1));
   assign last    = active_ff && (col_ff == COL_W'(GLYPH_WIDTH - 1)) && dx_last;

   // free again in the cycle that sends the final pixel, so rows run back to back
   assign busy   = active_ff && !last;
   assign accept = start && !busy;

   // column and replica counters
   always_comb begin
      active_in = active_ff;
      col_in    = col_ff;
      dx_in     = dx_ff;
      px_in     = px_ff;
      if (accept) begin
         active_in = 1'b1;
         col_in    = '0;
         dx_in     = '0;
         px_in     = '0;
      end else if (active_ff) begin
         if (last) begin
            active_in = 1'b0;
         end else begin
            px_in = px_ff + PX_W'(1);
            if (dx_last) begin
               dx_in  = '0;
               col_in = col_ff + COL_W'(1);
            end else begin
               dx_in = dx_ff + DX_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      col_ff <= col_in;
      dx_ff  <= dx_in;
      px_ff  <= px_in;
      if (accept) begin
         bits_ff      <= glyph_bits;
         origin_x_ff  <= origin_x;
         origin_y_ff  <= origin_y;
         glyph_row_ff <= glyph_row;
         sub_row_ff   <= sub_row;
         fg_ff        <= fg_color;
         bg_ff        <= bg_color;
      end
   end

   // pixel out: leftmost column is the top bit, hence the inverted column index
   always_comb begin
      token.valid     = active_ff;
      token.last      = last;
      token.px        = px_ff;
      token.color     = bits_ff[~col_ff] ? fg_ff : bg_ff;
      token.origin_x  = origin_x_ff;
      token.origin_y  = origin_y_ff;
      token.glyph_row = glyph_row_ff;
      token.sub_row   = sub_row_ff;
   end

endmodule
`default_nettype wire

/* rtl/gpx_pixel_pipe.sv */
`default_nettype none
module gpx_pixel_pipe
   import gpx_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire gpx_cfg_type   cfg,
   input  wire gpx_token_type token,
   output logic               rsp_strobe,
   output logic               rsp_write_enable,
   output logic [ADDR_W-1:0]  rsp_write_address,
   output logic [COLOR_W-1:0] rsp_write_data,
   output logic [FMT_W-1:0]   rsp_write_size,
   output logic               rsp_last_pixel
);

   localparam int POS_W  = COORD_W + 1;
   localparam int PROD_W = 2 * DIM_W;
   localparam int LIN_W  = PROD_W + 1;
   localparam int OFF_W  = LIN_W + 2;

   logic [SCALE_W-1:0] scale;
   assign scale = eff_scale(cfg.scale_factor);

   // ---------------- stage 1: pixel position and colour
   logic                    s1_valid_ff, s1_valid_in;
   logic                    s1_last_ff, s1_last_in;
   logic signed [POS_W-1:0] s1_x_ff, s1_x_in;
   logic signed [POS_W-1:0] s1_y_ff, s1_y_in;
   logic [COLOR_W-1:0]      s1_color_ff, s1_color_in;
   logic                    s1_ok_ff, s1_ok_in;
   logic [2*SCALE_W-1:0]    row_offset;

   always_comb begin
      row_offset  = {{SCALE_W{1'b0}}, token.glyph_row} * {{SCALE_W{1'b0}}, scale};
      s1_valid_in = token.valid;
      s1_last_in  = token.last;
      s1_color_in = token.color;
      s1_x_in     = $signed({token.origin_x[COORD_W-1], token.origin_x})
                  + $signed({{(POS_W-PX_W){1'b0}}, token.px});
      s1_y_in     = $signed({token.origin_y[COORD_W-1], token.origin_y})
                  + $signed({{(POS_W-2*SCALE_W){1'b0}}, row_offset})
                  + $signed({{(POS_W-SUBROW_W){1'b0}}, token.sub_row});
      // write enables: display on, base set, format usable, sub-row and row in range, not transparent
      s1_ok_in    = cfg.display_enable && (cfg.base_address != '0)
                  && (cfg.pixel_format != FMT_NONE)
                  && ({1'b0, token.sub_row} < scale)
                  && ({1'b0, token.glyph_row} < (ROW_W+1)'(GLYPH_HEIGHT))
                  && (token.color != TRANSPARENT_KEY);
   end

   // ---------------- stage 2: clipping, line product, data packing
   logic               s2_valid_ff, s2_valid_in;
   logic               s2_last_ff, s2_last_in;
   logic               s2_we_ff, s2_we_in;
   logic [PROD_W-1:0]  s2_prod_ff, s2_prod_in;
   logic [DIM_W-1:0]   s2_x_ff, s2_x_in;
   logic [COLOR_W-1:0] s2_data_ff, s2_data_in;
   logic               x_ok;
   logic               y_ok;

   always_comb begin
      x_ok        = !s1_x_ff[POS_W-1]
                  && (s1_x_ff[COORD_W-1:0] < {{(COORD_W-DIM_W){1'b0}}, cfg.frame_width});
      y_ok        = !s1_y_ff[POS_W-1]
                  && (s1_y_ff[COORD_W-1:0] < {{(COORD_W-DIM_W){1'b0}}, cfg.frame_height});
      s2_valid_in = s1_valid_ff;
      s2_last_in  = s1_last_ff;
      s2_we_in    = s1_ok_ff && x_ok && y_ok;
      s2_prod_in  = {{DIM_W{1'b0}}, s1_y_ff[DIM_W-1:0]} * {{DIM_W{1'b0}}, cfg.line_stride};
      s2_x_in     = s1_x_ff[DIM_W-1:0];
      case (cfg.pixel_format)
         FMT_ARGB32: s2_data_in = s1_color_ff;
         FMT_RGB24:  s2_data_in = {8'h00, s1_color_ff[23:0]};
         FMT_RGB565: s2_data_in = {16'h0000, s1_color_ff[23:19], s1_color_ff[15:10],
                                   s1_color_ff[7:3]};
         default:    s2_data_in = '0;
      endcase
   end

   // ---------------- stage 3: linear pixel index
   logic               s3_valid_ff;
   logic               s3_last_ff;
   logic               s3_we_ff;
   logic [LIN_W-1:0]   s3_lin_ff, s3_lin_in;
   logic [COLOR_W-1:0] s3_data_ff;

   assign s3_lin_in = {1'b0, s2_prod_ff} + {{(LIN_W-DIM_W){1'b0}}, s2_x_ff};

   // ---------------- stage 4: byte offset
   logic               s4_valid_ff;
   logic               s4_last_ff;
   logic               s4_we_ff;
   logic [OFF_W-1:0]   s4_off_ff, s4_off_in;
   logic [COLOR_W-1:0] s4_data_ff;

   always_comb begin
      case (cfg.pixel_format)
         FMT_ARGB32: s4_off_in = {s3_lin_ff, 2'b00};
         FMT_RGB24:  s4_off_in = {1'b0, s3_lin_ff, 1'b0} + {2'b00, s3_lin_ff};
         default:    s4_off_in = {1'b0, s3_lin_ff, 1'b0};
      endcase
   end

   // ---------------- stage 5: frame base, result register
   logic               out_valid_ff;
   logic               out_last_ff;
   logic               out_we_ff, out_we_in;
   logic [ADDR_W-1:0]  out_addr_ff, out_addr_in;
   logic [COLOR_W-1:0] out_data_ff, out_data_in;
   logic [FMT_W-1:0]   out_size_ff, out_size_in;

   // disabled writes carry all-zero fields
   always_comb begin
      out_we_in   = s4_we_ff;
      out_addr_in = '0;
      out_data_in = '0;
      out_size_in = '0;
      if (s4_we_ff) begin
         out_addr_in = cfg.base_address + {{(ADDR_W-OFF_W){1'b0}}, s4_off_ff};
         out_data_in = s4_data_ff;
         out_size_in = cfg.pixel_format;
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
         out_valid_ff <= s4_valid_ff;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s1_last_ff  <= s1_last_in;
      s1_x_ff     <= s1_x_in;
      s1_y_ff     <= s1_y_in;
      s1_color_ff <= s1_color_in;
      s1_ok_ff    <= s1_ok_in;
      s2_last_ff  <= s2_last_in;
      s2_we_ff    <= s2_we_in;
      s2_prod_ff  <= s2_prod_in;
      s2_x_ff     <= s2_x_in;
      s2_data_ff  <= s2_data_in;
      s3_last_ff  <= s2_last_ff;
      s3_we_ff    <= s2_we_ff;
      s3_lin_ff   <= s3_lin_in;
      s3_data_ff  <= s2_data_ff;
      s4_last_ff  <= s3_last_ff;
      s4_we_ff    <= s3_we_ff;
      s4_off_ff   <= s4_off_in;
      s4_data_ff  <= s3_data_ff;
      out_last_ff <= s4_last_ff;
      out_we_ff   <= out_we_in;
      out_addr_ff <= out_addr_in;
      out_data_ff <= out_data_in;
      out_size_ff <= out_size_in;
   end

   assign rsp_strobe        = out_valid_ff;
   assign rsp_write_enable  = out_valid_ff && out_we_ff;
   assign rsp_write_address = out_addr_ff;
   assign rsp_write_data    = out_data_ff;
   assign rsp_write_size    = out_size_ff;
   assign rsp_last_pixel    = out_valid_ff && out_last_ff;

endmodule
`default_nettype wire
